FILE: sv/cannm_pkg.sv
// ----------------------------------------------------------------------------
// cannm_pkg
// Shared types and constants of the CAN network-management state machine:
// event codes, state and mode codes, configuration layout and result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cannm_pkg;

    // Width of the timing configuration registers and of the register index.
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_ADDR_BITS = 3;

    // Repeat-message-request bit position inside the control bit vector byte.
    localparam int CBV_RMR_BIT = 0;

    // Configuration values after reset.
    localparam logic [CFG_WIDTH-1:0] RST_MAIN_PERIOD          = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT_TIME         = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] RST_REPEAT_MESSAGE_TIME  = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] RST_WAIT_BUS_SLEEP_TIME  = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] RST_MESSAGE_CYCLE_TIME   = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RST_MESSAGE_CYCLE_OFFSET = 16'd0;
    localparam logic                 RST_CBV_ENABLED          = 1'b1;

    // Events carried by one input beat.
    typedef enum logic [2:0] {
        ACT_TICK            = 3'd0,
        ACT_PASSIVE_STARTUP = 3'd1,
        ACT_REQUEST         = 3'd2,
        ACT_RELEASE         = 3'd3,
        ACT_REPEAT_REQUEST  = 3'd4,
        ACT_TX_CONFIRM      = 3'd5,
        ACT_RX              = 3'd6
    } t_action;

    // Network-management states.
    typedef enum logic [2:0] {
        ST_BUS_SLEEP = 3'd0,
        ST_PREPARE   = 3'd1,
        ST_READY     = 3'd2,
        ST_NORMAL    = 3'd3,
        ST_REPEAT    = 3'd4
    } t_nm_state;

    // Network-management modes.
    typedef enum logic [1:0] {
        MODE_BUS_SLEEP = 2'd0,
        MODE_PREPARE   = 2'd1,
        MODE_NETWORK   = 2'd2
    } t_nm_mode;

    // Notifications raised by an event.
    typedef enum logic [2:0] {
        NTF_NONE          = 3'd0,
        NTF_NETWORK_MODE  = 3'd1,
        NTF_PREPARE_SLEEP = 3'd2,
        NTF_BUS_SLEEP     = 3'd3,
        NTF_NETWORK_START = 3'd4
    } t_notify;

    // Status of an event.
    typedef enum logic {
        STS_OK           = 1'b0,
        STS_NOT_EXECUTED = 1'b1
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_MAIN_PERIOD          = 3'd0,
        CFG_TIMEOUT_TIME         = 3'd1,
        CFG_REPEAT_MESSAGE_TIME  = 3'd2,
        CFG_WAIT_BUS_SLEEP_TIME  = 3'd3,
        CFG_MESSAGE_CYCLE_TIME   = 3'd4,
        CFG_MESSAGE_CYCLE_OFFSET = 3'd5,
        CFG_CBV_ENABLED          = 3'd6
    } t_cfg_index;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] main_period;
        logic [CFG_WIDTH-1:0] timeout_time;
        logic [CFG_WIDTH-1:0] repeat_message_time;
        logic [CFG_WIDTH-1:0] wait_bus_sleep_time;
        logic [CFG_WIDTH-1:0] message_cycle_time;
        logic [CFG_WIDTH-1:0] message_cycle_offset;
        logic                 cbv_enabled;
    } t_cfg;

    // One result; the last member sits in the lowest bits.
    typedef struct packed {
        t_notify   notify;
        logic      tx_cbv;
        logic      transmit;
        t_nm_state nm_state;
        t_nm_mode  nm_mode;
        t_status   status;
    } t_result;

    localparam int RESULT_BITS = $bits(t_result);
    localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;
    localparam int OUT_BITS    = OUT_BYTES * 8;

    // Mode that belongs to a state.
    function automatic t_nm_mode f_mode_of(input t_nm_state s);
        t_nm_mode m;
        case (s)
            ST_BUS_SLEEP: m = MODE_BUS_SLEEP;
            ST_PREPARE:   m = MODE_PREPARE;
            default:      m = MODE_NETWORK;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cannm_engine.sv
// ----------------------------------------------------------------------------
// cannm_engine
// State registers of the network-management channel and the single-pass
// next-state logic that applies one event and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module cannm_engine
    import cannm_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [2:0] i_action,
    input  wire logic [7:0] i_rx_cbv,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    // Largest value a countdown can hold, in a 32-bit frame.
    localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

    t_nm_state            r_state,    n_state;
    logic                 r_req,      n_req;
    logic [TIME_BITS-1:0] r_timeout,  n_timeout;
    logic [TIME_BITS-1:0] r_repeat,   n_repeat;
    logic [TIME_BITS-1:0] r_cycle,    n_cycle;
    logic [TIME_BITS-1:0] r_wait,     n_wait;
    logic                 r_rbit,     n_rbit;

    // Reload value, saturated to the countdown width.
    function automatic logic [TIME_BITS-1:0] f_load(input logic [CFG_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > TIME_MAX) begin
            return '1;
        end
        return w[TIME_BITS-1:0];
    endfunction

    // A countdown expires when it is not above the main period.
    function automatic logic f_expired(input logic [TIME_BITS-1:0] t);
        return 32'(i_cfg.main_period) >= 32'(t);
    endfunction

    function automatic logic [TIME_BITS-1:0] f_dec(input logic [TIME_BITS-1:0] t);
        logic [31:0] d;
        d = 32'(t) - 32'(i_cfg.main_period);
        return d[TIME_BITS-1:0];
    endfunction

    // State registers, updated once per processed event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_BUS_SLEEP;
            r_req     <= 1'b0;
            r_timeout <= '0;
            r_repeat  <= '0;
            r_cycle   <= '0;
            r_wait    <= '0;
            r_rbit    <= 1'b0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_req     <= n_req;
            r_timeout <= n_timeout;
            r_repeat  <= n_repeat;
            r_cycle   <= n_cycle;
            r_wait    <= n_wait;
            r_rbit    <= n_rbit;
        end
    end

    // Next state and result for the event held in the input register.
    always_comb begin
        t_status  v_status;
        logic     v_tx;
        logic     v_txbit;
        t_notify  v_notify;
        t_nm_mode v_mode;
        logic     v_rx_repeat;

        n_state   = r_state;
        n_req     = r_req;
        n_timeout = r_timeout;
        n_repeat  = r_repeat;
        n_cycle   = r_cycle;
        n_wait    = r_wait;
        n_rbit    = r_rbit;
        v_status  = STS_OK;
        v_tx      = 1'b0;
        v_txbit   = 1'b0;
        v_notify  = NTF_NONE;
        v_mode    = f_mode_of(r_state);
        v_rx_repeat = i_cfg.cbv_enabled && i_rx_cbv[CBV_RMR_BIT];

        case (t_action'(i_action))
            ACT_TICK: begin
                if (v_mode == MODE_NETWORK) begin
                    // Network timeout: reload while sending, leave ready sleep.
                    if (f_expired(n_timeout)) begin
                        n_timeout = '0;
                        if (n_state inside {ST_REPEAT, ST_NORMAL}) begin
                            n_timeout = f_load(i_cfg.timeout_time);
                        end else if (n_state == ST_READY) begin
                            n_state  = ST_PREPARE;
                            n_wait   = f_load(i_cfg.wait_bus_sleep_time);
                            v_notify = NTF_PREPARE_SLEEP;
                        end
                    end else begin
                        n_timeout = f_dec(n_timeout);
                    end
                    // Message cycle: send one message per period.
                    if (n_state inside {ST_REPEAT, ST_NORMAL}) begin
                        if (f_expired(n_cycle)) begin
                            n_cycle = f_load(i_cfg.message_cycle_time);
                            v_tx    = 1'b1;
                            v_txbit = r_rbit && i_cfg.cbv_enabled;
                        end else begin
                            n_cycle = f_dec(n_cycle);
                        end
                    end
                    // Repeat message duration.
                    if (n_state == ST_REPEAT) begin
                        if (f_expired(n_repeat)) begin
                            n_repeat = '0;
                            n_state  = r_req ? ST_NORMAL : ST_READY;
                            if (i_cfg.cbv_enabled) begin
                                n_rbit = 1'b0;
                            end
                        end else begin
                            n_repeat = f_dec(n_repeat);
                        end
                    end
                end else if (v_mode == MODE_PREPARE) begin
                    if (f_expired(n_wait)) begin
                        n_wait   = '0;
                        n_state  = ST_BUS_SLEEP;
                        v_notify = NTF_BUS_SLEEP;
                    end else begin
                        n_wait = f_dec(n_wait);
                    end
                end
            end
            ACT_PASSIVE_STARTUP: begin
                if (v_mode == MODE_BUS_SLEEP) begin
                    n_state   = ST_REPEAT;
                    n_repeat  = f_load(i_cfg.repeat_message_time);
                    n_cycle   = f_load(i_cfg.message_cycle_offset);
                    n_timeout = f_load(i_cfg.timeout_time);
                    v_notify  = NTF_NETWORK_MODE;
                end else begin
                    v_status = STS_NOT_EXECUTED;
                end
            end
            ACT_REQUEST: begin
                n_req = 1'b1;
                if (v_mode != MODE_NETWORK) begin
                    n_state   = ST_REPEAT;
                    n_repeat  = f_load(i_cfg.repeat_message_time);
                    n_cycle   = f_load(i_cfg.message_cycle_offset);
                    n_timeout = f_load(i_cfg.timeout_time);
                    v_notify  = NTF_NETWORK_MODE;
                end else if (r_state == ST_READY) begin
                    n_state = ST_NORMAL;
                    n_cycle = f_load(i_cfg.message_cycle_offset);
                end
            end
            ACT_RELEASE: begin
                n_req = 1'b0;
                if (r_state == ST_NORMAL) begin
                    n_state = ST_READY;
                end
            end
            ACT_REPEAT_REQUEST: begin
                if (i_cfg.cbv_enabled && (r_state inside {ST_READY, ST_NORMAL})) begin
                    n_rbit   = 1'b1;
                    n_state  = ST_REPEAT;
                    n_repeat = f_load(i_cfg.repeat_message_time);
                    n_cycle  = f_load(i_cfg.message_cycle_offset);
                end else begin
                    v_status = STS_NOT_EXECUTED;
                end
            end
            ACT_TX_CONFIRM: begin
                if (v_mode == MODE_NETWORK) begin
                    n_timeout = f_load(i_cfg.timeout_time);
                end
            end
            ACT_RX: begin
                if (v_mode == MODE_BUS_SLEEP) begin
                    v_notify = NTF_NETWORK_START;
                end else if (v_mode == MODE_PREPARE) begin
                    n_state   = ST_REPEAT;
                    n_repeat  = f_load(i_cfg.repeat_message_time);
                    n_cycle   = f_load(i_cfg.message_cycle_offset);
                    n_timeout = f_load(i_cfg.timeout_time);
                    v_notify  = NTF_NETWORK_MODE;
                end else begin
                    n_timeout = f_load(i_cfg.timeout_time);
                    if (v_rx_repeat && (r_state inside {ST_READY, ST_NORMAL})) begin
                        n_state  = ST_REPEAT;
                        n_repeat = f_load(i_cfg.repeat_message_time);
                        n_cycle  = f_load(i_cfg.message_cycle_offset);
                    end
                end
            end
            default: begin
                v_status = STS_NOT_EXECUTED;
            end
        endcase

        o_result.status   = v_status;
        o_result.nm_mode  = f_mode_of(n_state);
        o_result.nm_state = n_state;
        o_result.transmit = v_tx;
        o_result.tx_cbv   = v_txbit;
        o_result.notify   = v_notify;
    end

endmodule

`default_nettype wire

FILE: sv/can_network_management_fsm.sv
// ----------------------------------------------------------------------------
// can_network_management_fsm
// One channel of the CAN network-management state machine with stream
// input and output and a plain configuration write port.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock while the result side takes
// beats and returns exactly one result beat per event. Each event is
// registered on input, applied to the channel state by the single-pass
// update in cannm_engine once the result register is free or being
// emptied, and written to the result register, which presents its result
// beat. Throughput is one event per clock for as long as the result side
// takes beats; the result register lets a new event enter while the
// previous result still waits. Configuration must be written by the user
// only while no event is in flight; the block itself does not enforce this.
`default_nettype none

module can_network_management_fsm
    import cannm_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Event stream.
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,  // [7:0] rx_cbv
    input  wire logic [2:0]               s_axis_tuser,  // [2:0] action
    // Result stream.
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [0] status, [2:1] nm_mode, [5:3] nm_state, [6] transmit, [7] tx_cbv,
    // [10:8] notify, [15:11] zero
    output logic [OUT_BITS-1:0]           m_axis_tdata,
    // Configuration writes.
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_WIDTH-1:0]     i_cfg_wdata
);

    logic       r_in_valid;
    logic [2:0] r_action;
    logic [7:0] r_rx_cbv;
    logic       r_out_valid;
    t_result    r_result;
    t_result    w_result;
    t_cfg       r_cfg;
    logic       w_advance;

    // An event moves on when the result register is free or being emptied.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BITS - RESULT_BITS){1'b0}}, r_result};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.main_period          <= RST_MAIN_PERIOD;
            r_cfg.timeout_time         <= RST_TIMEOUT_TIME;
            r_cfg.repeat_message_time  <= RST_REPEAT_MESSAGE_TIME;
            r_cfg.wait_bus_sleep_time  <= RST_WAIT_BUS_SLEEP_TIME;
            r_cfg.message_cycle_time   <= RST_MESSAGE_CYCLE_TIME;
            r_cfg.message_cycle_offset <= RST_MESSAGE_CYCLE_OFFSET;
            r_cfg.cbv_enabled          <= RST_CBV_ENABLED;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_MAIN_PERIOD:          r_cfg.main_period          <= i_cfg_wdata;
                CFG_TIMEOUT_TIME:         r_cfg.timeout_time         <= i_cfg_wdata;
                CFG_REPEAT_MESSAGE_TIME:  r_cfg.repeat_message_time  <= i_cfg_wdata;
                CFG_WAIT_BUS_SLEEP_TIME:  r_cfg.wait_bus_sleep_time  <= i_cfg_wdata;
                CFG_MESSAGE_CYCLE_TIME:   r_cfg.message_cycle_time   <= i_cfg_wdata;
                CFG_MESSAGE_CYCLE_OFFSET: r_cfg.message_cycle_offset <= i_cfg_wdata;
                CFG_CBV_ENABLED:          r_cfg.cbv_enabled          <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser;
            r_rx_cbv <= s_axis_tdata;
        end
    end

    // Channel state and event update.
    cannm_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_action (r_action),
        .i_rx_cbv (r_rx_cbv),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cannm_checker.sv
// ----------------------------------------------------------------------------
// cannm_checker
// Port-level checks on the result stream of the network-management channel,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module cannm_checker
    import cannm_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [OUT_BITS-1:0]      m_axis_tdata
);

    // No result is shown in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The reported mode always matches the reported state.
    a_mode_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[5:3] == ST_BUS_SLEEP && m_axis_tdata[2:1] == MODE_BUS_SLEEP) ||
            (m_axis_tdata[5:3] == ST_PREPARE && m_axis_tdata[2:1] == MODE_PREPARE) ||
            ((m_axis_tdata[5:3] == ST_READY || m_axis_tdata[5:3] == ST_NORMAL ||
              m_axis_tdata[5:3] == ST_REPEAT) && m_axis_tdata[2:1] == MODE_NETWORK))
        else $error("nm_mode does not match nm_state");

    // The repeat bit is only reported with a transmission.
    a_cbv_needs_transmit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |-> m_axis_tdata[6])
        else $error("tx_cbv set without transmit");

    // Only a transmitting state can send, and a send never carries a notification.
    a_transmit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |->
            ((m_axis_tdata[5:3] == ST_NORMAL || m_axis_tdata[5:3] == ST_REPEAT ||
              m_axis_tdata[5:3] == ST_READY) && m_axis_tdata[10:8] == NTF_NONE))
        else $error("transmit outside network mode");

    // A stalled result beat holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind can_network_management_fsm cannm_checker u_checker (.*);

`default_nettype wire

FILE: sim/can_network_management_fsm_test.sv
// ----------------------------------------------------------------------------
// can_network_management_fsm_test
// Self-checking bench for one CAN network-management channel.
// ----------------------------------------------------------------------------
// Events go in as stream beats and status beats come back, one per event.
// A scoreboard class tracks the channel state, its timers and its settings.
// For every accepted event it predicts the status beat, and it checks each
// returned beat field by field against the oldest prediction.
// The stimulus starts with a short directed walk through all states. It then
// runs several settings phases with random events, zero and full-scale
// settings among them. The sender works in bursts with gaps between them,
// and the result side stalls on a pattern of its own.
`default_nettype none

module can_network_management_fsm_test
    import cannm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no accepted beat before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Register index past the end of the register list; writes are dropped.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_INDEX = 3'd7;
    // Code past the last defined event.
    localparam logic [2:0] ACT_UNDEFINED = 3'd7;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_EVENTS = 60;

    // Channel state, timers and settings, together with the status beats
    // still owed by the block.
    class cannm_status_board;
        t_cfg      cfg;
        t_nm_state state;
        logic      requested;
        logic      rmr_out;
        // Timers at the block's default width of 16 bits.
        logic [CFG_WIDTH-1:0] timeout_left;
        logic [CFG_WIDTH-1:0] repeat_left;
        logic [CFG_WIDTH-1:0] cycle_left;
        logic [CFG_WIDTH-1:0] sleep_left;
        t_result   outcome;
        t_result   status_due[$];
        int        bad_beats;

        function new();
            cfg.main_period          = RST_MAIN_PERIOD;
            cfg.timeout_time         = RST_TIMEOUT_TIME;
            cfg.repeat_message_time  = RST_REPEAT_MESSAGE_TIME;
            cfg.wait_bus_sleep_time  = RST_WAIT_BUS_SLEEP_TIME;
            cfg.message_cycle_time   = RST_MESSAGE_CYCLE_TIME;
            cfg.message_cycle_offset = RST_MESSAGE_CYCLE_OFFSET;
            cfg.cbv_enabled          = RST_CBV_ENABLED;
            state        = ST_BUS_SLEEP;
            requested    = 1'b0;
            rmr_out      = 1'b0;
            timeout_left = '0;
            repeat_left  = '0;
            cycle_left   = '0;
            sleep_left   = '0;
            bad_beats    = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_WIDTH-1:0] value);
            case (idx)
                CFG_MAIN_PERIOD:          cfg.main_period = value;
                CFG_TIMEOUT_TIME:         cfg.timeout_time = value;
                CFG_REPEAT_MESSAGE_TIME:  cfg.repeat_message_time = value;
                CFG_WAIT_BUS_SLEEP_TIME:  cfg.wait_bus_sleep_time = value;
                CFG_MESSAGE_CYCLE_TIME:   cfg.message_cycle_time = value;
                CFG_MESSAGE_CYCLE_OFFSET: cfg.message_cycle_offset = value;
                CFG_CBV_ENABLED:          cfg.cbv_enabled = value[0];
                default: ;
            endcase
        endfunction

        function t_nm_mode mode_for(t_nm_state s);
            if (s == ST_BUS_SLEEP) begin
                return MODE_BUS_SLEEP;
            end
            if (s == ST_PREPARE) begin
                return MODE_PREPARE;
            end
            return MODE_NETWORK;
        endfunction

        // One tick off a countdown; a countdown not above the period clamps
        // to zero and reports expiry.
        function logic count_down_expired(inout logic [CFG_WIDTH-1:0] t);
            if (cfg.main_period >= t) begin
                t = '0;
                return 1'b1;
            end
            t = t - cfg.main_period;
            return 1'b0;
        endfunction

        function void enter_repeat();
            state       = ST_REPEAT;
            repeat_left = cfg.repeat_message_time;
            cycle_left  = cfg.message_cycle_offset;
        endfunction

        function void wake_up();
            enter_repeat();
            timeout_left   = cfg.timeout_time;
            outcome.notify = NTF_NETWORK_MODE;
        endfunction

        // Apply one accepted event and queue the status beat it causes.
        function void apply_event(logic [2:0] act, logic [7:0] rx_byte);
            t_nm_mode m;
            m = mode_for(state);
            outcome = '0;
            outcome.status = STS_OK;
            outcome.notify = NTF_NONE;
            case (act)
                ACT_TICK: begin
                    if (m == MODE_NETWORK) begin
                        if (count_down_expired(timeout_left)) begin
                            if (state == ST_REPEAT || state == ST_NORMAL) begin
                                timeout_left = cfg.timeout_time;
                            end else if (state == ST_READY) begin
                                state          = ST_PREPARE;
                                sleep_left     = cfg.wait_bus_sleep_time;
                                outcome.notify = NTF_PREPARE_SLEEP;
                            end
                        end
                        if (state == ST_REPEAT || state == ST_NORMAL) begin
                            if (count_down_expired(cycle_left)) begin
                                cycle_left       = cfg.message_cycle_time;
                                outcome.transmit = 1'b1;
                                outcome.tx_cbv   = rmr_out & cfg.cbv_enabled;
                            end
                        end
                        if (state == ST_REPEAT) begin
                            if (count_down_expired(repeat_left)) begin
                                if (requested) begin
                                    state = ST_NORMAL;
                                end else begin
                                    state = ST_READY;
                                end
                                if (cfg.cbv_enabled) begin
                                    rmr_out = 1'b0;
                                end
                            end
                        end
                    end else if (m == MODE_PREPARE) begin
                        if (count_down_expired(sleep_left)) begin
                            state          = ST_BUS_SLEEP;
                            outcome.notify = NTF_BUS_SLEEP;
                        end
                    end
                end
                ACT_PASSIVE_STARTUP: begin
                    if (m == MODE_BUS_SLEEP) begin
                        wake_up();
                    end else begin
                        outcome.status = STS_NOT_EXECUTED;
                    end
                end
                ACT_REQUEST: begin
                    requested = 1'b1;
                    if (m != MODE_NETWORK) begin
                        wake_up();
                    end else if (state == ST_READY) begin
                        state      = ST_NORMAL;
                        cycle_left = cfg.message_cycle_offset;
                    end
                end
                ACT_RELEASE: begin
                    requested = 1'b0;
                    if (state == ST_NORMAL) begin
                        state = ST_READY;
                    end
                end
                ACT_REPEAT_REQUEST: begin
                    if (cfg.cbv_enabled && (state == ST_READY || state == ST_NORMAL)) begin
                        rmr_out = 1'b1;
                        enter_repeat();
                    end else begin
                        outcome.status = STS_NOT_EXECUTED;
                    end
                end
                ACT_TX_CONFIRM: begin
                    if (m == MODE_NETWORK) begin
                        timeout_left = cfg.timeout_time;
                    end
                end
                ACT_RX: begin
                    if (m == MODE_BUS_SLEEP) begin
                        outcome.notify = NTF_NETWORK_START;
                    end else if (m == MODE_PREPARE) begin
                        wake_up();
                    end else begin
                        timeout_left = cfg.timeout_time;
                        if (cfg.cbv_enabled && rx_byte[CBV_RMR_BIT] &&
                            (state == ST_READY || state == ST_NORMAL)) begin
                            enter_repeat();
                        end
                    end
                end
                default: begin
                    outcome.status = STS_NOT_EXECUTED;
                end
            endcase
            outcome.nm_state = state;
            outcome.nm_mode  = mode_for(state);
            status_due.push_back(outcome);
        endfunction

        function void report_failure(string msg);
            bad_beats++;
            if (bad_beats <= 10) begin
                $display("tb: mismatch: %s", msg);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                report_failure($sformatf("%s expected %0d, got %0d", name, want, got));
            end
        endfunction

        // Check one returned status beat against the oldest prediction.
        function void check_status_beat(logic [OUT_BITS-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[RESULT_BITS-1:0]);
            if (status_due.size() == 0) begin
                report_failure($sformatf("status beat 0x%0h with nothing outstanding", data));
                return;
            end
            want = status_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("nm_mode", want.nm_mode, got.nm_mode);
            compare_field("nm_state", want.nm_state, got.nm_state);
            compare_field("transmit", want.transmit, got.transmit);
            compare_field("tx_cbv", want.tx_cbv, got.tx_cbv);
            compare_field("notify", want.notify, got.notify);
            compare_field("padding", 0, data[OUT_BITS-1:RESULT_BITS]);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = '0;
    logic [2:0]               s_axis_tuser = ACT_TICK;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_axis_tdata;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_WIDTH-1:0]     i_cfg_wdata = '0;

    cannm_status_board board;
    int unsigned       quiet_cycles = 0;
    int unsigned       sink_cycle = 0;

    can_network_management_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Result side: stalls follow a pattern that steps through four levels of readiness.
    always @(negedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        case ((sink_cycle / 97) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Check every status beat the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_status_beat(m_axis_tdata);
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one event beat and hold it until it is taken. Returns on the
    // falling edge after acceptance with valid still high.
    task automatic send_event(input logic [2:0] act, input logic [7:0] rx_byte);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= rx_byte;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.apply_event(act, rx_byte);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (board.status_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        board.set_reg(idx, value);
    endtask

    // Write the whole register set, plus a stray write past the list.
    task automatic load_settings(input t_cfg c);
        write_reg(CFG_MAIN_PERIOD, c.main_period);
        write_reg(CFG_TIMEOUT_TIME, c.timeout_time);
        write_reg(CFG_REPEAT_MESSAGE_TIME, c.repeat_message_time);
        write_reg(CFG_WAIT_BUS_SLEEP_TIME, c.wait_bus_sleep_time);
        write_reg(CFG_MESSAGE_CYCLE_TIME, c.message_cycle_time);
        write_reg(CFG_MESSAGE_CYCLE_OFFSET, c.message_cycle_offset);
        write_reg(CFG_CBV_ENABLED, {{(CFG_WIDTH-1){1'b0}}, c.cbv_enabled});
        write_reg(CFG_SPARE_INDEX, CFG_WIDTH'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_cfg random_settings(input int unsigned span);
        t_cfg c;
        c.main_period          = CFG_WIDTH'($urandom_range(1, span / 4 + 1));
        c.timeout_time         = CFG_WIDTH'($urandom_range(0, span));
        c.repeat_message_time  = CFG_WIDTH'($urandom_range(0, span));
        c.wait_bus_sleep_time  = CFG_WIDTH'($urandom_range(0, span));
        c.message_cycle_time   = CFG_WIDTH'($urandom_range(0, span));
        c.message_cycle_offset = CFG_WIDTH'($urandom_range(0, span));
        c.cbv_enabled          = 1'($urandom_range(0, 1));
        return c;
    endfunction

    initial begin
        t_cfg        plan [PHASE_COUNT];
        t_cfg        fast;
        int unsigned left;
        int unsigned burst;
        int unsigned pick;
        logic [2:0]  act;

        board = new();

        // Settings for the random phases: ordinary, all zero, all full scale
        // without control byte, tiny, random small and full-range, small fixed.
        plan[0] = '{main_period: 16'd50, timeout_time: 16'd400,
                    repeat_message_time: 16'd300, wait_bus_sleep_time: 16'd250,
                    message_cycle_time: 16'd120, message_cycle_offset: 16'd30,
                    cbv_enabled: 1'b1};
        plan[1] = '0;
        plan[2] = '{main_period: 16'hFFFF, timeout_time: 16'hFFFF,
                    repeat_message_time: 16'hFFFF, wait_bus_sleep_time: 16'hFFFF,
                    message_cycle_time: 16'hFFFF, message_cycle_offset: 16'hFFFF,
                    cbv_enabled: 1'b0};
        plan[3] = '{main_period: 16'd1, timeout_time: 16'd5,
                    repeat_message_time: 16'd4, wait_bus_sleep_time: 16'd3,
                    message_cycle_time: 16'd2, message_cycle_offset: 16'd1,
                    cbv_enabled: 1'b0};
        plan[4] = random_settings(400);
        plan[5] = random_settings(65535);
        plan[6] = random_settings(200);
        plan[7] = '{main_period: 16'd10, timeout_time: 16'd60,
                    repeat_message_time: 16'd40, wait_bus_sleep_time: 16'd30,
                    message_cycle_time: 16'd20, message_cycle_offset: 16'd0,
                    cbv_enabled: 1'b1};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk under the reset settings, starting in bus sleep.
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_RX, 8'hFF);
        send_event(ACT_RELEASE, 8'h00);
        send_event(ACT_REPEAT_REQUEST, 8'h00);
        send_event(ACT_TX_CONFIRM, 8'h00);
        send_event(ACT_UNDEFINED, 8'hFF);
        send_event(ACT_PASSIVE_STARTUP, 8'h00);
        send_event(ACT_PASSIVE_STARTUP, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_REPEAT_REQUEST, 8'h00);
        pause_sender(1);
        wait_drained();

        // A full-scale period makes every countdown expire at each tick, so
        // each tick moves the channel one step.
        fast = '{main_period: 16'hFFFF, timeout_time: 16'd300,
                 repeat_message_time: 16'd200, wait_bus_sleep_time: 16'd200,
                 message_cycle_time: 16'd100, message_cycle_offset: 16'd0,
                 cbv_enabled: 1'b1};
        load_settings(fast);
        send_event(ACT_REQUEST, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_REPEAT_REQUEST, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_RELEASE, 8'h00);
        send_event(ACT_RX, 8'h01);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_REQUEST, 8'h00);
        send_event(ACT_RELEASE, 8'h00);
        send_event(ACT_TX_CONFIRM, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_RX, 8'h00);
        send_event(ACT_RELEASE, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_REQUEST, 8'h00);
        send_event(ACT_RELEASE, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_TICK, 8'h00);

        // Random phases; each starts once every status beat has come back.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            pause_sender(1);
            wait_drained();
            load_settings(plan[p]);
            left = PHASE_EVENTS;
            while (left > 0) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && left > 0) begin
                    // Ticks dominate so the timers run out and the channel
                    // travels through all of its states.
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        act = ACT_TICK;
                    end else if (pick < 57) begin
                        act = ACT_REQUEST;
                    end else if (pick < 69) begin
                        act = ACT_RELEASE;
                    end else if (pick < 75) begin
                        act = ACT_PASSIVE_STARTUP;
                    end else if (pick < 83) begin
                        act = ACT_REPEAT_REQUEST;
                    end else if (pick < 90) begin
                        act = ACT_TX_CONFIRM;
                    end else if (pick < 99) begin
                        act = ACT_RX;
                    end else begin
                        act = ACT_UNDEFINED;
                    end
                    send_event(act, 8'($urandom_range(0, 255)));
                    burst--;
                    left--;
                end
                pause_sender($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (board.status_due.size() != 0) begin
            board.report_failure($sformatf("%0d status beats never arrived",
                                           board.status_due.size()));
        end
        if (board.bad_beats == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/cannm_pkg.sv
sv/cannm_engine.sv
sv/can_network_management_fsm.sv
sv/cannm_checker.sv
sim/can_network_management_fsm_test.sv
